// ===== sv/z2hb_pkg.sv =====
// Shared types and constants for the Z2 gauge heat-bath sweep engine.
`default_nettype none
package z2hb_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATHER,
    ST_DECIDE,
    ST_ACCESS,
    ST_RDWAIT,
    ST_EMIT
  } state_e;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam logic [1:0] REG_PROB_TWO  = 2'd0;
  localparam logic [1:0] REG_PROB_FOUR = 2'd1;
  localparam logic [1:0] REG_PROB_SIX  = 2'd2;

  localparam logic [16:0] PROB_TWO_RST  = 17'd57723;
  localparam logic [16:0] PROB_FOUR_RST = 17'd64357;
  localparam logic [16:0] PROB_SIX_RST  = 17'd65374;
  localparam logic [16:0] PROB_ONE      = 17'd65536;
  localparam logic [16:0] PROB_HALF     = 17'd32768;

  typedef struct packed {
    logic [4:0] x0;
    logic [4:0] x1;
    logic [4:0] x2;
    logic [5:0] t;
    logic [1:0] dir;
  } site_t;

  typedef struct packed {
    logic [1:0] qi;
    logic [2:0] k;
  } nbr_step_t;

endpackage
`default_nettype wire

// ===== sv/z2hb_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module z2hb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/z2hb_nbr_addr.sv =====
// Neighbor link address generator for the six staples around a link.
`default_nettype none
module z2hb_nbr_addr import z2hb_pkg::*; #(
  parameter int SPACE_EXTENT = 8,
  parameter int TIME_EXTENT  = 8,
  parameter int AW           = 12
) (
  input  wire site_t           site_i,
  input  wire nbr_step_t       step_i,
  output logic      [AW-1:0]   addr_o
);

  localparam logic [1:0] MV_NONE = 2'd0;
  localparam logic [1:0] MV_UP   = 2'd1;
  localparam logic [1:0] MV_DOWN = 2'd2;
  localparam logic [6:0] S_EXT = 7'(SPACE_EXTENT);
  localparam logic [6:0] T_EXT = 7'(TIME_EXTENT);

  function automatic logic [5:0] coord_move(logic [5:0] c, logic [6:0] ext, logic [1:0] mv);
    logic [6:0] nx;
    logic [6:0] top;
    begin
      nx  = {1'b0, c} + 7'd1;
      top = ext - 7'd1;
      case (mv)
        MV_UP:   coord_move = (nx == ext) ? 6'd0 : nx[5:0];
        MV_DOWN: coord_move = (c == 6'd0) ? top[5:0] : c - 6'd1;
        default: coord_move = c;
      endcase
    end
  endfunction

  logic [1:0] q;
  logic [1:0] ldir;
  logic [1:0] mq;
  logic [1:0] md;
  logic [5:0] base_c [4];
  logic [5:0] moved_c [4];

  always_comb begin
    q = (step_i.qi >= site_i.dir) ? step_i.qi + 2'd1 : step_i.qi;
    case (step_i.k)
      3'd0, 3'd1, 3'd2: mq = MV_DOWN;
      3'd4:             mq = MV_UP;
      default:          mq = MV_NONE;
    endcase
    md   = (step_i.k == 3'd2 || step_i.k == 3'd3) ? MV_UP : MV_NONE;
    ldir = (step_i.k == 3'd1 || step_i.k == 3'd4) ? site_i.dir : q;
    base_c[0] = {1'b0, site_i.x0};
    base_c[1] = {1'b0, site_i.x1};
    base_c[2] = {1'b0, site_i.x2};
    base_c[3] = site_i.t;
    for (int a = 0; a < 4; a++) begin
      moved_c[a] = coord_move(base_c[a], (a == 3) ? T_EXT : S_EXT,
                              (2'(a) == q) ? mq : ((2'(a) == site_i.dir) ? md : MV_NONE));
    end
  end

  assign addr_o = ((((AW'(moved_c[0]) * AW'(SPACE_EXTENT) + AW'(moved_c[1]))
                   * AW'(SPACE_EXTENT) + AW'(moved_c[2])) * AW'(TIME_EXTENT)
                   + AW'(moved_c[3])) * AW'(4)) + AW'(ldir);

endmodule
`default_nettype wire

// ===== sv/z2hb_decide.sv =====
// Heat-bath decision and saturating plaquette accumulation.
`default_nettype none
module z2hb_decide import z2hb_pkg::*; (
  input  wire logic signed [3:0]  sum_i,
  input  wire logic        [15:0] rnd_i,
  input  wire logic        [16:0] prob_two_i,
  input  wire logic        [16:0] prob_four_i,
  input  wire logic        [16:0] prob_six_i,
  input  wire logic signed [17:0] acc_i,
  output logic                    plus_o,
  output logic signed      [17:0] acc_o
);

  logic        [3:0]  mag;
  logic        [16:0] praw;
  logic        [16:0] psat;
  logic        [16:0] thr;
  logic signed [3:0]  delta;
  logic signed [18:0] wide;

  always_comb begin
    mag = sum_i[3] ? 4'(-sum_i) : 4'(sum_i);
    case (mag)
      4'd2:    praw = prob_two_i;
      4'd4:    praw = prob_four_i;
      default: praw = prob_six_i;
    endcase
    psat = (praw > PROB_ONE) ? PROB_ONE : praw;
    if (mag == 4'd0) begin
      thr = PROB_HALF;
    end else if (!sum_i[3]) begin
      thr = psat;
    end else begin
      thr = PROB_ONE - psat;
    end
    plus_o = {1'b0, rnd_i} < thr;
    delta  = plus_o ? sum_i : -sum_i;
    wide   = {acc_i[17], acc_i} + {{15{delta[3]}}, delta};
    if (wide[18] != wide[17]) begin
      acc_o = wide[18] ? 18'sh20000 : 18'sh1FFFF;
    end else begin
      acc_o = wide[17:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/z2_gauge_heatbath_sweep.sv =====
// Top level of the Z2 lattice gauge heat-bath sweep engine.
// Each input word carries a command in tuser and yields exactly one output word.
// An update reads the eighteen neighbor links one per cycle through the single port
// of the link memory, followed by the decision and write-back state and the output
// state. A write passes through the access and output states, a read also through a
// read-wait state. After reset the link memory is cleared to +1 one link per cycle,
// covering all SPACE_EXTENT^3 * TIME_EXTENT * 4 links (16384 at the default size); no
// word is accepted meanwhile, while configuration writes are taken as usual.
`default_nettype none
module z2_gauge_heatbath_sweep import z2hb_pkg::*; #(
  parameter int SPACE_EXTENT = 8,
  parameter int TIME_EXTENT  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // link_address[13:0], link_value[14], random_fraction[30:15], zero[31]
  input  wire logic [31:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // link_index[13:0], link_sign[14], staple_sum[18:15], plaquette_total[36:19],
  // sweep_done[37], zero[39:38]
  output logic      [39:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  localparam int LINK_COUNT = SPACE_EXTENT * SPACE_EXTENT * SPACE_EXTENT * TIME_EXTENT * 4;
  localparam int AW = $clog2(LINK_COUNT);
  localparam logic [AW-1:0] LAST_LINK = AW'(LINK_COUNT - 1);

  state_e state_q, state_d;

  logic [16:0] prob_two_q, prob_four_q, prob_six_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] cursor_q;
  site_t site_q;
  logic signed [17:0] acc_q;

  logic [1:0]  cmd_q;
  logic [13:0] addr_q;
  logic        val_q;
  logic [15:0] rnd_q;

  nbr_step_t step_q;
  logic issue_done_q, pend_q, pend_last_q, par_q;
  logic [2:0] pend_k_q;
  logic signed [3:0] sum_q;

  logic [13:0]        res_idx_q;
  logic               res_sign_q;
  logic signed [3:0]  res_staple_q;
  logic signed [17:0] res_total_q;
  logic               res_done_q;

  logic        out_valid_q;
  logic [37:0] out_q;

  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] nbr_addr;
  logic          plus;
  logic signed [17:0] acc_next;
  logic          in_range;
  logic          s_fire, emit_load, link_bit, is_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign emit_load     = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign in_range      = {18'd0, addr_q} < 32'(LINK_COUNT);
  assign link_bit      = par_q ^ ram_rdata;
  assign is_last       = (cursor_q == LAST_LINK);

  z2hb_ram #(.WIDTH(1), .DEPTH(LINK_COUNT)) u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  z2hb_nbr_addr #(.SPACE_EXTENT(SPACE_EXTENT), .TIME_EXTENT(TIME_EXTENT), .AW(AW)) u_nbr (
    .site_i (site_q),
    .step_i (step_q),
    .addr_o (nbr_addr)
  );

  z2hb_decide u_decide (
    .sum_i       (sum_q),
    .rnd_i       (rnd_q),
    .prob_two_i  (prob_two_q),
    .prob_four_i (prob_four_q),
    .prob_six_i  (prob_six_q),
    .acc_i       (acc_q),
    .plus_o      (plus),
    .acc_o       (acc_next)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == LAST_LINK) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_fire) begin
          state_d = (s_axis_tuser == CMD_UPDATE) ? ST_GATHER : ST_ACCESS;
        end
      end
      ST_GATHER: if (pend_q && pend_last_q) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_EMIT;
      ST_ACCESS: state_d = (cmd_q == CMD_WRITE) ? ST_EMIT : ST_RDWAIT;
      ST_RDWAIT: state_d = ST_EMIT;
      ST_EMIT:   if (emit_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = nbr_addr;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      ST_DECIDE: begin
        ram_we    = 1'b1;
        ram_addr  = cursor_q;
        ram_wdata = !plus;
      end
      ST_ACCESS: begin
        ram_we    = (cmd_q == CMD_WRITE) && in_range;
        ram_addr  = AW'(addr_q);
        ram_wdata = val_q;
      end
      default: ram_addr = nbr_addr;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      site_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      prob_two_q  <= PROB_TWO_RST;
      prob_four_q <= PROB_FOUR_RST;
      prob_six_q  <= PROB_SIX_RST;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROB_TWO:  prob_two_q  <= cfg_data_i;
          REG_PROB_FOUR: prob_four_q <= cfg_data_i;
          REG_PROB_SIX:  prob_six_q  <= cfg_data_i;
          default:       prob_six_q  <= prob_six_q;
        endcase
      end
      if (state_q == ST_DECIDE) begin
        if (is_last) begin
          cursor_q <= '0;
          site_q   <= '0;
          acc_q    <= '0;
        end else begin
          cursor_q <= cursor_q + AW'(1);
          acc_q    <= acc_next;
          if (site_q.dir != 2'd3) begin
            site_q.dir <= site_q.dir + 2'd1;
          end else begin
            site_q.dir <= 2'd0;
            if (site_q.t != 6'(TIME_EXTENT - 1)) begin
              site_q.t <= site_q.t + 6'd1;
            end else begin
              site_q.t <= '0;
              if (site_q.x2 != 5'(SPACE_EXTENT - 1)) begin
                site_q.x2 <= site_q.x2 + 5'd1;
              end else begin
                site_q.x2 <= '0;
                if (site_q.x1 != 5'(SPACE_EXTENT - 1)) begin
                  site_q.x1 <= site_q.x1 + 5'd1;
                end else begin
                  site_q.x1 <= '0;
                  site_q.x0 <= site_q.x0 + 5'd1;
                end
              end
            end
          end
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q        <= s_axis_tuser;
      addr_q       <= s_axis_tdata[13:0];
      val_q        <= s_axis_tdata[14];
      rnd_q        <= s_axis_tdata[30:15];
      step_q       <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      par_q        <= 1'b0;
      sum_q        <= '0;
    end
    if (state_q == ST_GATHER) begin
      pend_q      <= !issue_done_q;
      pend_k_q    <= step_q.k;
      pend_last_q <= (step_q.qi == 2'd2) && (step_q.k == 3'd5);
      if (!issue_done_q) begin
        if (step_q.k == 3'd5) begin
          step_q.k <= 3'd0;
          if (step_q.qi == 2'd2) begin
            issue_done_q <= 1'b1;
          end else begin
            step_q.qi <= step_q.qi + 2'd1;
          end
        end else begin
          step_q.k <= step_q.k + 3'd1;
        end
      end
      if (pend_q) begin
        if (pend_k_q == 3'd2 || pend_k_q == 3'd5) begin
          sum_q <= sum_q + (link_bit ? 4'sb1111 : 4'sb0001);
          par_q <= 1'b0;
        end else begin
          par_q <= link_bit;
        end
      end
    end
    if (state_q == ST_DECIDE) begin
      res_idx_q    <= 14'(cursor_q);
      res_sign_q   <= !plus;
      res_staple_q <= sum_q;
      res_total_q  <= acc_next;
      res_done_q   <= is_last;
    end
    if (state_q == ST_ACCESS) begin
      res_idx_q    <= addr_q;
      res_sign_q   <= in_range && val_q;
      res_staple_q <= '0;
      res_total_q  <= acc_q;
      res_done_q   <= 1'b0;
    end
    if (state_q == ST_RDWAIT) begin
      res_sign_q <= in_range && ram_rdata;
    end
    if (emit_load) begin
      out_q <= {res_done_q, res_total_q, res_staple_q, res_sign_q, res_idx_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  a_gather_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GATHER) |-> !ram_we)
    else $error("Link memory written while neighbors are gathered.");

  a_staple_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (sum_q[0] == 1'b0) && (sum_q != 4'sb1000))
    else $error("Staple sum is outside the even range from -6 to 6.");

  a_sweep_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) && is_last |=> (cursor_q == '0) && (acc_q == '0))
    else $error("Cursor or accumulator did not clear at the end of a sweep.");

endmodule
`default_nettype wire
